// File: src/sdos_pkg.sv
`timescale 1ns / 1ps

package sdos_pkg;

   localparam int CAPACITY_DEF = 256;

   localparam int INDEX_W = 16;
   localparam int DEPTH_W = 16;

   // req side field layout
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   // rsp side field layout
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_TUSER_W = 2;

   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_POP = 1'b1;

   typedef struct packed {
      logic                      is_tile;
      logic [INDEX_W-1:0]        index;
      logic signed [DEPTH_W-1:0] depth;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP
   } cell_op_type;

   // broadcast from the control to every cell
   typedef struct packed {
      cell_op_type op;
      entry_type   new_entry;
   } cell_ctrl_type;

endpackage

// File: src/sdos_cell.sv
`timescale 1ns / 1ps

module sdos_cell (
   input  logic                    clock,
   input  sdos_pkg::cell_ctrl_type ctrl,
   input  logic                    occupied,
   input  logic                    prev_open,
   input  sdos_pkg::entry_type     prev_entry,
   input  sdos_pkg::entry_type     next_entry,
   output sdos_pkg::entry_type     entry,
   output logic                    open
);

   sdos_pkg::entry_type entry_ff;
   sdos_pkg::entry_type entry_in;

   // new entry goes ahead of this one only when strictly deeper (keeps arrival order)
   assign open  = !occupied || ($signed(ctrl.new_entry.depth) > $signed(entry_ff.depth));
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      unique case (ctrl.op)
         sdos_pkg::CELL_INSERT: begin
            if (open) begin
               entry_in = prev_open ? prev_entry : ctrl.new_entry;
            end
         end
         sdos_pkg::CELL_POP: begin
            entry_in = next_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/stable_depth_order_sorter.sv
`timescale 1ns / 1ps

// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | tuser {is_tile, kind}, tdata {hidden, depth, index}
// rsp     | out | rsp_tvalid/rsp_tready  | tuser {out_is_tile, valid_res}, tdata {depth, index},
//         |     |                        | tlast = store empty after this pop
//
// one beat is taken per cycle while req_tready is high: every cell compares its
// depth with the incoming entry in the same cycle and the whole row shifts at once;
// a pop result is registered and shows on rsp in the cycle after acceptance
// reset (synchronous, active high) empties the store and drops any pending result
// req_tready stays high unless a result is held in the output register and
// rsp_tready is low; adds then stall too, keeping one slot of output storage

module stable_depth_order_sorter #(
   parameter int CAPACITY = sdos_pkg::CAPACITY_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sdos_pkg::REQ_TDATA_W-1:0] req_tdata,  // [15:0] item_index, [31:16] item_depth,
                                                        // [32] hidden, rest zero
   input  logic [sdos_pkg::REQ_TUSER_W-1:0] req_tuser,  // [0] kind, [1] is_tile
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sdos_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // [15:0] out_index, [31:16] out_depth
   output logic [sdos_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // [0] valid_res, [1] out_is_tile
   output logic                             rsp_tlast   // last
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // fill level of the row; cell i is occupied while i < count
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   // output register
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic [sdos_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [sdos_pkg::RSP_TDATA_W-1:0] rsp_data_in;
   logic [sdos_pkg::RSP_TUSER_W-1:0] rsp_user_ff;
   logic [sdos_pkg::RSP_TUSER_W-1:0] rsp_user_in;
   logic                             rsp_last_ff;
   logic                             rsp_last_in;

   logic accept;
   logic is_pop;
   logic is_add;
   logic empty;
   logic full;

   sdos_pkg::cell_ctrl_type ctrl;
   sdos_pkg::entry_type     cell_entry [CAPACITY];
   logic                    cell_open  [CAPACITY];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign empty  = (count_ff == '0);
   assign full   = (count_ff >= CNT_W'(CAPACITY));
   assign is_pop = accept && (req_tuser[0] == sdos_pkg::KIND_POP);
   // hidden adds and adds into a full row are dropped without a trace
   assign is_add = accept && (req_tuser[0] == sdos_pkg::KIND_ADD) && !req_tdata[32] && !full;

   // broadcast to the row
   always_comb begin
      ctrl.new_entry.is_tile = req_tuser[1];
      ctrl.new_entry.index   = req_tdata[15:0];
      ctrl.new_entry.depth   = req_tdata[31:16];
      if (is_add) begin
         ctrl.op = sdos_pkg::CELL_INSERT;
      end else if (is_pop && !empty) begin
         ctrl.op = sdos_pkg::CELL_POP;
      end else begin
         ctrl.op = sdos_pkg::CELL_HOLD;
      end
   end

   // row of cells, head at cell 0; an insert shifts everything behind the slot
   // one place back, a pop shifts everything one place forward
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                occupied;
      logic                prev_open;
      sdos_pkg::entry_type prev_entry;
      sdos_pkg::entry_type next_entry;

      assign occupied = (CNT_W'(i) < count_ff);

      if (i == 0) begin : g_head
         assign prev_open  = 1'b0;
         assign prev_entry = ctrl.new_entry;
      end else begin : g_body
         assign prev_open  = cell_open[i-1];
         assign prev_entry = cell_entry[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_entry = cell_entry[i];
      end else begin : g_mid
         assign next_entry = cell_entry[i+1];
      end

      sdos_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .occupied   (occupied),
         .prev_open  (prev_open),
         .prev_entry (prev_entry),
         .next_entry (next_entry),
         .entry      (cell_entry[i]),
         .open       (cell_open[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (is_add) begin
         count_in = count_ff + CNT_W'(1);
      end else if (is_pop && !empty) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // result beat built from the head cell; an empty pop returns zeros
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (is_pop) begin
         rsp_valid_in = 1'b1;
         if (empty) begin
            rsp_data_in = '0;
            rsp_user_in = '0;
            rsp_last_in = 1'b1;
         end else begin
            rsp_data_in = {cell_entry[0].depth, cell_entry[0].index};
            rsp_user_in = {cell_entry[0].is_tile, 1'b1};
            rsp_last_in = (count_ff == CNT_W'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
